/* design/bsp_point_contents_walk_top_macros.svh */
// assertion macros for the bsp point contents walk block
// used by the top level; clock clk_i and reset rst_ni are taken from the including scope
`ifndef BSP_POINT_CONTENTS_WALK_TOP_MACROS_SVH
`define BSP_POINT_CONTENTS_WALK_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define BPCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bpcw assertion failed");
// checked at every edge, reset included
`define BPCW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bpcw assertion failed");
`else
`define BPCW_ASSERT(lbl, prop)
`define BPCW_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* design/bpcw_pkg.sv */
// shared types, codes and constants of the bsp point contents walk block
// no dependencies; imported by every module of the block
package bpcw_pkg;

  localparam int unsigned NODES_DEF     = 1024;
  localparam int unsigned PLANES_DEF    = 1024;
  localparam int unsigned MAX_STEPS_DEF = 64;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CHILD_W = 11;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VEC_W   = 32;
  localparam int unsigned CONT_W  = 5;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // plane kinds
  localparam logic [KIND_W-1:0] KIND_X       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_Y       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_Z       = 2'd2;
  localparam logic [KIND_W-1:0] KIND_GENERAL = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_FIRST_NODE = 1'b0;
  localparam logic REG_LAST_NODE  = 1'b1;

  typedef enum logic [1:0] {
    ACT_NODE_WR  = 2'd0,
    ACT_PLANE_WR = 2'd1,
    ACT_QUERY    = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NODE_RD,
    ST_PLANE_RD,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_ACC,
    ST_DECIDE,
    ST_DONE
  } ctrl_state_e;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]                pad;
    logic signed [VEC_W-1:0]   plane_dist;
    logic signed [VEC_W-1:0]   vec_z;
    logic signed [VEC_W-1:0]   vec_y;
    logic signed [VEC_W-1:0]   vec_x;
    logic [KIND_W-1:0]         plane_kind;
    logic signed [CHILD_W-1:0] back_child;
    logic signed [CHILD_W-1:0] front_child;
    logic [IDX_W-1:0]          plane_ref;
    logic [IDX_W-1:0]          index;
  } in_item_t;

  typedef struct packed {
    logic                     pad;
    logic                     step_overflow;
    logic                     bad_node;
    logic signed [CONT_W-1:0] contents;
  } result_t;

  typedef struct packed {
    logic signed [CHILD_W-1:0] back_child;
    logic signed [CHILD_W-1:0] front_child;
    logic [IDX_W-1:0]          plane_ref;
  } node_ent_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VEC_W-1:0] nx;
    logic signed [VEC_W-1:0] ny;
    logic signed [VEC_W-1:0] nz;
    logic signed [VEC_W-1:0] offset;
  } plane_ent_t;

  typedef struct packed {
    logic              wr_node;
    logic              wr_plane;
    logic              capture;
    logic              rd_node;
    logic              rd_plane;
    logic              acc_init;
    logic              acc_add;
    logic              prod_load;
    logic [KIND_W-1:0] prod_axis;
    logic              advance;
    logic              set_leaf;
    logic              set_bad;
    logic              set_over;
  } dp_cmd_t;

  typedef struct packed {
    logic node_bad;
    logic general;
    logic child_leaf;
    logic step_last;
  } dp_sts_t;

endpackage

/* design/bpcw_ctrl.sv */
// walk sequencer: accepts items, steps the datapath through node visits
// depends on bpcw_pkg
module bpcw_ctrl import bpcw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  action_e action_i,
  input  logic    out_free_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    in_ready_o,
  output logic    load_out_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && action_i == ACT_QUERY) state_d = ST_NODE_RD;
      end
      ST_NODE_RD: begin
        state_d = sts_i.node_bad ? ST_DONE : ST_PLANE_RD;
      end
      ST_PLANE_RD: state_d = ST_MUL_X;
      ST_MUL_X: begin
        state_d = sts_i.general ? ST_MUL_Y : ST_DECIDE;
      end
      ST_MUL_Y:   state_d = ST_MUL_Z;
      ST_MUL_Z:   state_d = ST_MUL_ACC;
      ST_MUL_ACC: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (sts_i.child_leaf || sts_i.step_last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_NODE_RD;
        end
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    load_out_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            ACT_NODE_WR:  cmd_o.wr_node  = 1'b1;
            ACT_PLANE_WR: cmd_o.wr_plane = 1'b1;
            ACT_QUERY:    cmd_o.capture  = 1'b1;
            default:      cmd_o = '0;
          endcase
        end
      end
      ST_NODE_RD: begin
        cmd_o.rd_node = 1'b1;
        cmd_o.set_bad = sts_i.node_bad;
      end
      ST_PLANE_RD: cmd_o.rd_plane = 1'b1;
      ST_MUL_X: begin
        cmd_o.acc_init  = sts_i.general;
        cmd_o.prod_load = sts_i.general;
        cmd_o.prod_axis = KIND_X;
      end
      ST_MUL_Y: begin
        cmd_o.acc_add   = 1'b1;
        cmd_o.prod_load = 1'b1;
        cmd_o.prod_axis = KIND_Y;
      end
      ST_MUL_Z: begin
        cmd_o.acc_add   = 1'b1;
        cmd_o.prod_load = 1'b1;
        cmd_o.prod_axis = KIND_Z;
      end
      ST_MUL_ACC: cmd_o.acc_add = 1'b1;
      ST_DECIDE: begin
        cmd_o.set_leaf = sts_i.child_leaf;
        cmd_o.set_over = !sts_i.child_leaf && sts_i.step_last;
        cmd_o.advance  = !sts_i.child_leaf && !sts_i.step_last;
      end
      ST_DONE: load_out_o = out_free_i;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* design/bpcw_datapath.sv */
// node and plane tables, shared multiplier, accumulator and walk registers
// depends on bpcw_pkg; driven by bpcw_ctrl
module bpcw_datapath import bpcw_pkg::*; #(
  parameter int unsigned NODES     = NODES_DEF,
  parameter int unsigned PLANES    = PLANES_DEF,
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  in_item_t         item_i,
  input  logic [IDX_W-1:0] first_node_i,
  input  logic [IDX_W-1:0] last_node_i,
  output dp_sts_t          sts_o,
  output result_t          result_o
);

  localparam int unsigned NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned PLANE_AW = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int unsigned STEP_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned PROD_W   = 2 * VEC_W;
  localparam int unsigned ACC_W    = PROD_W + 2;
  localparam int unsigned FRAC_W   = 16;

  node_ent_t  node_mem  [NODES];
  plane_ent_t plane_mem [PLANES];

  node_ent_t               node_q;
  plane_ent_t              plane_q;
  logic                    pl_ok_q;
  logic [IDX_W-1:0]        num_q;
  logic [STEP_W-1:0]       step_q;
  logic signed [VEC_W-1:0] px_q, py_q, pz_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  result_t                 res_q;

  logic [NODE_AW-1:0]        node_addr;
  logic [PLANE_AW-1:0]       plane_addr;
  logic                      node_slot_ok, plane_slot_ok;
  logic [KIND_W-1:0]         kind_eff;
  logic signed [VEC_W-1:0]   dist_eff;
  logic signed [VEC_W-1:0]   coord;
  logic signed [VEC_W:0]     axial_diff;
  logic signed [VEC_W-1:0]   mul_a, mul_b;
  logic                      neg;
  logic signed [CHILD_W-1:0] child;

  assign node_addr     = NODE_AW'(num_q);
  assign plane_addr    = PLANE_AW'(node_q.plane_ref);
  assign node_slot_ok  = 32'(item_i.index) < NODES;
  assign plane_slot_ok = 32'(item_i.index) < PLANES;

  // node table
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_node && node_slot_ok) begin
      node_mem[NODE_AW'(item_i.index)] <= '{back_child:  item_i.back_child,
                                           front_child: item_i.front_child,
                                           plane_ref:   item_i.plane_ref};
    end
    if (cmd_i.rd_node) begin
      node_q <= node_mem[node_addr];
    end
  end

  // plane table
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_plane && plane_slot_ok) begin
      plane_mem[PLANE_AW'(item_i.index)] <= '{kind:   item_i.plane_kind,
                                             nx:     item_i.vec_x,
                                             ny:     item_i.vec_y,
                                             nz:     item_i.vec_z,
                                             offset: item_i.plane_dist};
    end
    if (cmd_i.rd_plane) begin
      plane_q <= plane_mem[plane_addr];
      pl_ok_q <= 32'(node_q.plane_ref) < PLANES;
    end
  end

  // plane reference past the table acts as x plane at zero
  assign kind_eff = pl_ok_q ? plane_q.kind : KIND_X;
  assign dist_eff = pl_ok_q ? plane_q.offset : '0;

  always_comb begin
    case (kind_eff)
      KIND_X:  coord = px_q;
      KIND_Y:  coord = py_q;
      default: coord = pz_q;
    endcase
  end

  assign axial_diff = (VEC_W+1)'(coord) - (VEC_W+1)'(dist_eff);

  always_comb begin
    case (cmd_i.prod_axis)
      KIND_X: begin
        mul_a = plane_q.nx;
        mul_b = px_q;
      end
      KIND_Y: begin
        mul_a = plane_q.ny;
        mul_b = py_q;
      end
      default: begin
        mul_a = plane_q.nz;
        mul_b = pz_q;
      end
    endcase
  end

  // exact dot product minus dist scaled to q34.32
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_load) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_init) begin
      acc_q <= -$signed({{(ACC_W-VEC_W-FRAC_W){dist_eff[VEC_W-1]}}, dist_eff,
                         {FRAC_W{1'b0}}});
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign neg   = (kind_eff == KIND_GENERAL) ? acc_q[ACC_W-1] : axial_diff[VEC_W];
  assign child = neg ? node_q.back_child : node_q.front_child;

  // walk position and step count
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      num_q  <= item_i.index;
      step_q <= '0;
      px_q   <= item_i.vec_x;
      py_q   <= item_i.vec_y;
      pz_q   <= item_i.vec_z;
    end else if (cmd_i.advance) begin
      num_q  <= child[IDX_W-1:0];
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (cmd_i.set_leaf) begin
      res_q <= '{pad: 1'b0, step_overflow: 1'b0, bad_node: 1'b0,
                 contents: child[CONT_W-1:0]};
    end else if (cmd_i.set_bad) begin
      res_q <= '{pad: 1'b0, step_overflow: 1'b0, bad_node: 1'b1, contents: '0};
    end else if (cmd_i.set_over) begin
      res_q <= '{pad: 1'b0, step_overflow: 1'b1, bad_node: 1'b0, contents: '0};
    end
  end

  assign sts_o.node_bad   = (num_q < first_node_i) || (num_q > last_node_i) ||
                            (32'(num_q) >= NODES);
  assign sts_o.general    = kind_eff == KIND_GENERAL;
  assign sts_o.child_leaf = child[CHILD_W-1];
  assign sts_o.step_last  = step_q == STEP_W'(MAX_STEPS - 1);
  assign result_o         = res_q;

endmodule

/* design/bsp_point_contents_walk_top.sv */
// a table write is taken while idle; a query walks each node through node read, plane read
// and the x product to the decision, with y, z and accumulate steps for a general plane; a bad
// node ends the walk; one query at a time, the next accept once the result is loaded, later by
// any output stall; per node two registered table reads, then one shared 32x32 multiplier
// runs three products for a general plane; reset: rst_ni async active low; clears sequencer,
// output valid and range registers (first_node 0, last_node 1023); tables undefined until written
`include "bsp_point_contents_walk_top_macros.svh"

module bsp_point_contents_walk_top import bpcw_pkg::*; #(
  parameter int unsigned NODES     = NODES_DEF,
  parameter int unsigned PLANES    = PLANES_DEF,
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // index, plane_ref, front_child, back_child, plane_kind, vec_x, vec_y, vec_z,
  // plane_dist, 4 zero bits
  input  logic [175:0]      s_axis_tdata,
  // action
  input  logic [1:0]        s_axis_tuser,
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // contents, bad_node, step_overflow, 1 zero bit
  output logic [7:0]        m_axis_tdata,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // node range registers
  logic [IDX_W-1:0] first_node_q, first_node_d;
  logic [IDX_W-1:0] last_node_q, last_node_d;
  logic             cfg_wr;
  logic             reg_idx;

  // result output register, parts the walk from the downstream stall
  logic    m_valid_q, m_valid_d;
  result_t m_data_q, m_data_d;

  in_item_t item;
  action_e  action;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  result_t  result;
  logic     in_ready;
  logic     load_out;
  logic     out_free;

  assign item   = in_item_t'(s_axis_tdata);
  assign action = action_e'(s_axis_tuser);

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    first_node_d = first_node_q;
    last_node_d  = last_node_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_FIRST_NODE: first_node_d = pwdata[IDX_W-1:0];
        REG_LAST_NODE:  last_node_d  = pwdata[IDX_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FIRST_NODE: prdata = APB_DW'(first_node_q);
      REG_LAST_NODE:  prdata = APB_DW'(last_node_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_node_q <= '0;
      last_node_q  <= '1;
    end else begin
      first_node_q <= first_node_d;
      last_node_q  <= last_node_d;
    end
  end

  // ---------------- sequencer and datapath ----------------
  bpcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (action),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready),
    .load_out_o (load_out)
  );

  bpcw_datapath #(
    .NODES     (NODES),
    .PLANES    (PLANES),
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_i       (item),
    .first_node_i (first_node_q),
    .last_node_i  (last_node_q),
    .sts_o        (sts),
    .result_o     (result)
  );

  assign s_axis_tready = in_ready;

  // ---------------- output register ----------------
  // new items are taken while a result still waits here
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (load_out) begin
      m_valid_d = 1'b1;
      m_data_d  = result;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------- assertions ----------------
  // a query transaction keeps the input closed while the walk runs
  `BPCW_ASSERT(a_query_closes_input, s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_QUERY |=> !s_axis_tready)
  // flagged results carry no contents and never both flags
  `BPCW_ASSERT(a_flags_exclusive, m_axis_tvalid && (m_axis_tdata[5] || m_axis_tdata[6]) |-> m_axis_tdata[4:0] == '0 && !(m_axis_tdata[5] && m_axis_tdata[6]))
  // a stalled result stays put until it is taken
  `BPCW_ASSERT(a_result_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  // in the cycle after reset is sampled low, no result is shown and the input side is open
  `BPCW_ASSERT_ALWAYS(a_reset_state, !rst_ni |=> !m_axis_tvalid && s_axis_tready)

endmodule

/* tb/bpcw_checker.sv */
`timescale 1ns / 100ps
// result checker for the bsp point contents walk block: keeps its own node and plane
// tables and range registers, predicts every query and compares the result stream
// depends on bpcw_pkg for the stream layouts, actions, plane kinds and register codes
module bpcw_checker import bpcw_pkg::*; #(
  parameter int unsigned NODES     = NODES_DEF,
  parameter int unsigned PLANES    = PLANES_DEF,
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [175:0]      s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [7:0]        m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                fails_o,
  output int                pending_o,
  output int                results_o,
  output int                bad_o,
  output int                over_o
);

  node_ent_t        node_mem  [1 << IDX_W];
  plane_ent_t       plane_mem [1 << IDX_W];
  logic [IDX_W-1:0] lo_node;
  logic [IDX_W-1:0] hi_node;
  result_t          contents_due [$];
  result_t          got;
  result_t          want;
  in_item_t         item;
  logic [APB_DW-1:0] reg_want;
  int               fails;
  int               n_res;
  int               n_bad;
  int               n_over;

  initial begin
    fails  = 0;
    n_res  = 0;
    n_bad  = 0;
    n_over = 0;
  end

  // exact sign test of the plane distance, true when the point lies behind the plane
  function automatic logic behind_plane(plane_ent_t pl, logic signed [VEC_W-1:0] px,
                                        logic signed [VEC_W-1:0] py,
                                        logic signed [VEC_W-1:0] pz);
    logic signed [95:0] wx, wy, wz, vx, vy, vz, dot, limit;
    logic signed [VEC_W-1:0] coord;
    if (pl.kind == KIND_GENERAL) begin
      wx = 96'(pl.nx);
      wy = 96'(pl.ny);
      wz = 96'(pl.nz);
      vx = 96'(px);
      vy = 96'(py);
      vz = 96'(pz);
      dot = wx * vx + wy * vy + wz * vz;
      // floor(dot / 2^16) < dist is the same as dot < dist * 2^16
      limit = 96'(pl.offset);
      limit = limit <<< 16;
      return dot < limit;
    end
    case (pl.kind)
      KIND_Y:  coord = py;
      KIND_Z:  coord = pz;
      default: coord = px;
    endcase
    return coord < pl.offset;
  endfunction

  // walks the tree from the start node to a leaf, a bad node or the step limit
  function automatic result_t locate_leaf(logic [IDX_W-1:0] start,
                                          logic signed [VEC_W-1:0] px,
                                          logic signed [VEC_W-1:0] py,
                                          logic signed [VEC_W-1:0] pz);
    result_t r;
    int unsigned num;
    node_ent_t ent;
    plane_ent_t pl;
    logic signed [CHILD_W-1:0] child;
    r = '0;
    r.step_overflow = 1'b1;
    num = 32'(start);
    for (int s = 0; s < MAX_STEPS; s++) begin
      if (num < lo_node || num > hi_node || num >= NODES) begin
        r.bad_node = 1'b1;
        r.step_overflow = 1'b0;
        break;
      end
      ent = node_mem[num];
      // a plane slot past the table acts as x = 0
      pl = (ent.plane_ref < PLANES) ? plane_mem[ent.plane_ref] : '0;
      child = behind_plane(pl, px, py, pz) ? ent.back_child : ent.front_child;
      if (child[CHILD_W-1]) begin
        r.contents = child[CONT_W-1:0];
        r.step_overflow = 1'b0;
        break;
      end
      num = 32'(child[CHILD_W-2:0]);
    end
    return r;
  endfunction

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_node = '0;
      hi_node = '1;
      contents_due.delete();
    end else begin
      // result side
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_res++;
        if (contents_due.size() == 0) begin
          note_fail($sformatf("result with nothing pending: contents %0d bad %0b over %0b",
                              got.contents, got.bad_node, got.step_overflow));
        end else begin
          want = contents_due.pop_front();
          if (want.bad_node) n_bad++;
          if (want.step_overflow) n_over++;
          if (got.contents !== want.contents || got.bad_node !== want.bad_node ||
              got.step_overflow !== want.step_overflow) begin
            note_fail($sformatf(
              "result %0d: contents exp %0d got %0d, bad exp %0b got %0b, over exp %0b got %0b",
              n_res, want.contents, got.contents, want.bad_node, got.bad_node,
              want.step_overflow, got.step_overflow));
          end
        end
      end
      // input side
      if (s_axis_tvalid && s_axis_tready) begin
        item = s_axis_tdata;
        case (s_axis_tuser)
          ACT_NODE_WR: begin
            if (item.index < NODES)
              node_mem[item.index] = {item.back_child, item.front_child, item.plane_ref};
          end
          ACT_PLANE_WR: begin
            if (item.index < PLANES)
              plane_mem[item.index] = {item.plane_kind, item.vec_x, item.vec_y, item.vec_z,
                                       item.plane_dist};
          end
          ACT_QUERY: begin
            contents_due.push_back(locate_leaf(item.index, item.vec_x, item.vec_y,
                                               item.vec_z));
          end
          default: ;
        endcase
      end
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_LAST_NODE) hi_node = pwdata[IDX_W-1:0];
          else lo_node = pwdata[IDX_W-1:0];
        end else begin
          reg_want = (paddr[2] == REG_LAST_NODE) ? APB_DW'(hi_node) : APB_DW'(lo_node);
          if (prdata !== reg_want)
            note_fail($sformatf("register read at %0d: exp %0d got %0d",
                                paddr, reg_want, prdata));
        end
      end
    end
    fails_o   <= fails;
    pending_o <= contents_due.size();
    results_o <= n_res;
    bad_o     <= n_bad;
    over_o    <= n_over;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// top of the bsp point contents walk testbench: clock, reset, stimulus and verdict
// depends on bpcw_pkg, the block bsp_point_contents_walk_top and the bpcw_checker module
module tb;
  import bpcw_pkg::*;

  localparam int NPOOL       = 40;    // node slots used by the trees
  localparam int PPOOL       = 24;    // plane slots
  localparam int QUIET_LIMIT = 4000;  // cycles with no transaction before giving up
  localparam int NPHASE      = 6;
  localparam logic [1:0] ACT_SPARE = 2'd3;  // action code with no function

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // index, plane_ref, front_child, back_child, plane_kind, vec_x, vec_y, vec_z,
  // plane_dist, 4 zero bits
  logic [175:0]      s_axis_tdata = '0;
  // action
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // contents, bad_node, step_overflow, 1 zero bit
  logic [7:0]        m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fails, pending, results, bad_seen, over_seen;

  // stimulus bookkeeping: which pool entries hold written data
  logic [IDX_W-1:0] node_slot  [NPOOL];
  bit               node_ok    [NPOOL];
  logic [IDX_W-1:0] plane_slot [PPOOL];
  bit               plane_ok   [PPOOL];
  logic [IDX_W-1:0] lo_cur = '0;
  logic [IDX_W-1:0] hi_cur = '1;
  bit               idle_on = 1'b1;
  int               n_sent = 0;
  int               n_queries = 0;
  int               ready_left = 0;
  int               quiet = 0;

  always #5 clk_i = ~clk_i;

  bsp_point_contents_walk_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bpcw_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fails_o(fails), .pending_o(pending), .results_o(results),
    .bad_o(bad_seen), .over_o(over_seen)
  );

  // result back-pressure: ready-high runs and stalls of random length,
  // held high once idling is switched off near the end
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
      ready_left <= 0;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        ready_left <= $urandom_range(1, 40);
      end else begin
        m_axis_tready <= 1'b0;
        ready_left <= $urandom_range(1, 12);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // watchdog: any transaction on either stream or the register port restarts the count
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results still pending",
               quiet, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly values within +-8.0 so axial planes split points both ways, some full range
  function automatic logic [VEC_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // leaf contents codes, now and then one below -16 so only the low bits survive
  function automatic logic signed [CHILD_W-1:0] leaf_code();
    if ($urandom_range(0, 9) == 0) return CHILD_W'(-17 - int'($urandom_range(0, 1007)));
    return CHILD_W'(-1 - int'($urandom_range(0, 15)));
  endfunction

  function automatic logic signed [CHILD_W-1:0] node_ref(int j);
    return {1'b0, node_slot[j]};
  endfunction

  // children point at lower pool entries so trees stay acyclic, except for a few
  // links upward or to the node itself that can make the walk loop
  function automatic logic signed [CHILD_W-1:0] pick_child(int k);
    int cand[$];
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return leaf_code();
    for (int j = 0; j < NPOOL; j++)
      if (node_ok[j] && ((r < 95) ? (j < k) : (j > k))) cand.push_back(j);
    if (r >= 95) cand.push_back(k);
    if (cand.size() == 0) return leaf_code();
    return node_ref(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  // fields an action does not use still carry random bits
  function automatic in_item_t scramble();
    in_item_t it;
    it.pad         = '0;
    it.index       = IDX_W'($urandom_range(0, 1023));
    it.plane_ref   = IDX_W'($urandom_range(0, 1023));
    it.front_child = CHILD_W'($urandom_range(0, 2047));
    it.back_child  = CHILD_W'($urandom_range(0, 2047));
    it.plane_kind  = KIND_W'($urandom_range(0, 3));
    it.vec_x       = $urandom;
    it.vec_y       = $urandom;
    it.vec_z       = $urandom;
    it.plane_dist  = $urandom;
    return it;
  endfunction

  // drives one transaction and returns in the time step where it is taken
  task automatic send_item(input logic [1:0] act, input in_item_t it);
    s_axis_tuser  <= act;
    s_axis_tdata  <= it;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic put_plane(input int k, input logic [KIND_W-1:0] kind,
                           input logic [VEC_W-1:0] nx, input logic [VEC_W-1:0] ny,
                           input logic [VEC_W-1:0] nz, input logic [VEC_W-1:0] dist_val);
    in_item_t it;
    it = scramble();
    it.index      = plane_slot[k];
    it.plane_kind = kind;
    it.vec_x      = nx;
    it.vec_y      = ny;
    it.vec_z      = nz;
    it.plane_dist = dist_val;
    plane_ok[k]   = 1'b1;
    send_item(ACT_PLANE_WR, it);
  endtask

  task automatic put_node(input int k, input int pk, input logic signed [CHILD_W-1:0] front,
                          input logic signed [CHILD_W-1:0] back);
    in_item_t it;
    it = scramble();
    it.index       = node_slot[k];
    it.plane_ref   = plane_slot[pk];
    it.front_child = front;
    it.back_child  = back;
    node_ok[k]     = 1'b1;
    send_item(ACT_NODE_WR, it);
  endtask

  task automatic ask_point(input logic [IDX_W-1:0] start, input logic [VEC_W-1:0] x,
                           input logic [VEC_W-1:0] y, input logic [VEC_W-1:0] z);
    in_item_t it;
    it = scramble();
    it.index = start;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    n_queries++;
    send_item(ACT_QUERY, it);
  endtask

  task automatic send_noise();
    send_item(ACT_SPARE, scramble());
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // one register transaction: setup phase, access phase, then a free phase
  task automatic reg_access(input logic wr, input logic reg_sel, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // the range registers only change with the block idle
  task automatic set_range(input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] last);
    wait_drained();
    repeat (8) @(posedge clk_i);
    reg_access(1'b1, REG_FIRST_NODE, APB_DW'(first));
    reg_access(1'b1, REG_LAST_NODE, APB_DW'(last));
    reg_access(1'b0, REG_FIRST_NODE, '0);
    reg_access(1'b0, REG_LAST_NODE, '0);
    lo_cur = first;
    hi_cur = last;
  endtask

  // random traffic: mostly queries into the written trees, with node and plane
  // rewrites in between; unused actions do not count toward the total
  task automatic run_mix(input int count, input bit pause_midway);
    int n, r, k, pk;
    logic [IDX_W-1:0] start;
    n = 0;
    while (n < count) begin
      maybe_gap();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_noise();
        continue;
      end
      if (r < 20) begin
        k = $urandom_range(0, NPOOL - 1);
        do pk = $urandom_range(0, PPOOL - 1); while (!plane_ok[pk]);
        node_ok[k] = 1'b1;
        put_node(k, pk, pick_child(k), pick_child(k));
      end else if (r < 32) begin
        put_plane($urandom_range(0, PPOOL - 1), KIND_W'($urandom_range(0, 3)), rand_q16(),
                  rand_q16(), rand_q16(), rand_q16());
      end else begin
        start = IDX_W'($urandom_range(0, 1023));
        // an arbitrary start only where it is out of range and so never read
        if ($urandom_range(0, 9) != 0 || (start >= lo_cur && start <= hi_cur)) begin
          do k = $urandom_range(0, NPOOL - 1); while (!node_ok[k]);
          start = node_slot[k];
        end
        ask_point(start, rand_q16(), rand_q16(), rand_q16());
      end
      n++;
      // hold the sender until every pending result is back
      if (pause_midway && n == count / 2) wait_drained();
    end
  endtask

  logic [IDX_W-1:0] first_set [NPHASE];
  logic [IDX_W-1:0] last_set  [NPHASE];
  int               count_set [NPHASE];
  bit               taken     [1 << IDX_W];
  int               s;

  initial begin
    // pool slots: both ends of the index range plus distinct random ones
    node_slot[0] = '0;
    node_slot[1] = '1;
    taken[0] = 1'b1;
    taken[1023] = 1'b1;
    for (int k = 2; k < NPOOL; k++) begin
      do s = $urandom_range(1, 1022); while (taken[s]);
      taken[s] = 1'b1;
      node_slot[k] = IDX_W'(s);
    end
    for (int k = 0; k < (1 << IDX_W); k++) taken[k] = 1'b0;
    plane_slot[0] = '0;
    plane_slot[1] = '1;
    taken[0] = 1'b1;
    taken[1023] = 1'b1;
    for (int k = 2; k < PPOOL; k++) begin
      do s = $urandom_range(1, 1022); while (taken[s]);
      taken[s] = 1'b1;
      plane_slot[k] = IDX_W'(s);
    end

    // range settings: default, a random window, single node at each end,
    // an empty range with first above last, default again without idling
    first_set[0] = '0;   last_set[0] = '1;   count_set[0] = 200;
    first_set[1] = IDX_W'($urandom_range(0, 400));
    last_set[1]  = IDX_W'($urandom_range(500, 1022)); count_set[1] = 150;
    first_set[2] = '0;   last_set[2] = '0;   count_set[2] = 40;
    first_set[3] = '1;   last_set[3] = '1;   count_set[3] = 40;
    first_set[4] = IDX_W'(700); last_set[4] = IDX_W'(300); count_set[4] = 30;
    first_set[5] = '0;   last_set[5] = '1;   count_set[5] = 170;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // range registers read back their reset values
    reg_access(1'b0, REG_FIRST_NODE, '0);
    reg_access(1'b0, REG_LAST_NODE, '0);

    // directed planes: axial at 5.0, general with a tiny negative normal for floor
    // rounding, axial at both ends of the distance range, general with extreme values
    put_plane(0, KIND_X, rand_q16(), rand_q16(), rand_q16(), 32'h0005_0000);
    put_plane(1, KIND_GENERAL, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    put_plane(2, KIND_Y, rand_q16(), rand_q16(), rand_q16(), 32'h8000_0000);
    put_plane(3, KIND_Z, rand_q16(), rand_q16(), rand_q16(), 32'h7fff_ffff);
    put_plane(4, KIND_GENERAL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);

    // directed nodes: two leaf pairs (one with codes below -16), a two-level node,
    // a node that loops on itself, and a node above the two-level one
    put_node(0, 0, -11'sd1, -11'sd16);
    put_node(1, 1, -11'sd1024, -11'sd17);
    put_node(2, 2, node_ref(0), node_ref(1));
    put_node(3, 3, node_ref(3), node_ref(3));
    put_node(4, 4, node_ref(2), node_ref(1));

    // exactly on the plane goes front, just below goes back
    ask_point(node_slot[0], 32'h0005_0000, rand_q16(), rand_q16());
    ask_point(node_slot[0], 32'h0004_ffff, rand_q16(), rand_q16());
    // general plane: a product of -2^-32 floors to a negative distance
    ask_point(node_slot[1], 32'h0000_0001, rand_q16(), rand_q16());
    ask_point(node_slot[1], 32'h0, rand_q16(), rand_q16());
    ask_point(node_slot[1], 32'h8000_0000, rand_q16(), rand_q16());
    ask_point(node_slot[2], 32'h0005_0000, 32'h8000_0000, rand_q16());
    // self loop runs into the step limit
    ask_point(node_slot[3], rand_q16(), rand_q16(), 32'h0);
    send_noise();
    ask_point(node_slot[4], 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    ask_point(node_slot[4], 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);

    for (int p = 0; p < NPHASE; p++) begin
      if (p == NPHASE - 1) idle_on = 1'b0;
      set_range(first_set[p], last_set[p]);
      run_mix(count_set[p], p == 0);
    end

    wait_drained();
    repeat (30) @(posedge clk_i);

    $display("%0d items sent, %0d of them point queries, over %0d node-range settings",
             n_sent, n_queries, NPHASE);
    $display("%0d results compared: %0d out-of-range node walks, %0d step-limit walks",
             results, bad_seen, over_seen);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/bpcw_pkg.sv
design/bpcw_ctrl.sv
design/bpcw_datapath.sv
design/bsp_point_contents_walk_top.sv
tb/bpcw_checker.sv
tb/tb.sv
